/* sv/schwarz_quartet_pass_counter_top_defines.svh */
// ----------------------------------------------------------------------------
// Schwarz quartet pass counter: assertion macros
// Shared property forms; each expects clk_i and rst_ni in scope.
// ----------------------------------------------------------------------------
`ifndef SCHWARZ_QUARTET_PASS_COUNTER_TOP_DEFINES_SVH
`define SCHWARZ_QUARTET_PASS_COUNTER_TOP_DEFINES_SVH

// Same-cycle implication.
`define SQPC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SQPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/sqpc_pkg.sv */
// ----------------------------------------------------------------------------
// sqpc_pkg
// Types, sizes and helpers shared by the quartet pass counter modules.
// ----------------------------------------------------------------------------
package sqpc_pkg;

  localparam int MaxShells   = 64;
  localparam int ShellW      = (MaxShells > 1) ? $clog2(MaxShells) : 1;
  localparam int NumW        = $clog2(MaxShells + 1);
  localparam int TableSize   = MaxShells * (MaxShells + 1) / 2;
  localparam int SlotW       = (TableSize > 1) ? $clog2(TableSize) : 1;
  localparam int PairW       = $clog2(TableSize + 1);
  localparam int FieldShellW = 6;
  localparam int ShellCntW   = 7;
  localparam int BoundW      = 31;
  localparam int ThrW        = 64;
  localparam int ProdW       = 2 * BoundW;
  localparam int CountW      = 22;
  localparam int CmdW        = 2;
  localparam int CfgIdxW     = 1;
  localparam int RowW        = FieldShellW + NumW + 2;

  typedef enum logic [CmdW-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_COUNT = 2'd2
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PASS_THRESHOLD = 1'b0,
    CFG_SHELL_COUNT    = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    WALK_IDLE,
    WALK_SETTLE,
    WALK_OUTER_RD,
    WALK_OUTER_MUL,
    WALK_OUTER_CMP,
    WALK_INNER,
    WALK_DRAIN,
    WALK_DONE
  } walk_state_e;

  typedef struct packed {
    logic [CmdW-1:0]        command;
    logic [FieldShellW-1:0] first_shell;
    logic [FieldShellW-1:0] second_shell;
    logic [BoundW-1:0]      pair_bound;
  } in_word_t;

  typedef struct packed {
    logic [CountW-1:0] passing_count;
    logic [CountW-1:0] total_quartets;
  } out_word_t;

  typedef struct packed {
    logic start;
    logic bypass;
  } walk_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } walk_stat_t;

  typedef struct packed {
    logic              en;
    logic [SlotW-1:0]  addr;
    logic [BoundW-1:0] data;
  } ram_wr_t;

  typedef struct packed {
    logic             en;
    logic [SlotW-1:0] addr;
  } ram_rd_t;

  // Packed upper-triangle slot of pair (lo, hi), lo <= hi.
  function automatic logic [SlotW-1:0] slot_of(logic [FieldShellW-1:0] lo,
                                               logic [FieldShellW-1:0] hi);
    logic [RowW-1:0] row;
    row = RowW'(lo) * (RowW'(2 * MaxShells + 1) - RowW'(lo));
    return SlotW'(row >> 1) + SlotW'(hi) - SlotW'(lo);
  endfunction

endpackage

/* sv/schwarz_quartet_pass_counter_top.sv */
// ----------------------------------------------------------------------------
// schwarz_quartet_pass_counter_top
// Pair bound table with running maximum and a screened quartet counter.
// ----------------------------------------------------------------------------
//  channel   signals                           handshake
//  command   start, busy, cmd_i                accepted when start && !busy
//  result    done_o, result_o                  one-cycle strobe, no stall
//  config    cfg_we_i, cfg_idx_i, cfg_data_i   written when cfg_we_i high
//
//  Clear and load leave busy low, so a new word can follow every cycle.
//  A count holds busy for its walk: each outer pair is read, multiplied
//  and screened; every outer pair that passes then reads each inner pair
//  and drains the quartet pipe; a closing state ends the walk and done_o
//  follows in the next cycle. No shells or a non-positive threshold skip the walk.
//  Reset clears control, maximum and config; result_o and table stay unknown.
//  The receiver cannot stall: done_o marks result_o for one cycle.
// ----------------------------------------------------------------------------
module schwarz_quartet_pass_counter_top
  import sqpc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  in_word_t           cmd_i,
  output logic               done_o,
  output out_word_t          result_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [ThrW-1:0]    cfg_data_i
);

  logic [ThrW-1:0]      thr_q;
  logic [ShellCntW-1:0] shell_cnt_q;
  logic [BoundW-1:0]    largest_q, largest_d;
  logic [NumW-1:0]      n_sat;
  logic [PairW-1:0]     pairs_q;
  logic [CountW-1:0]    total_q;
  logic [2*NumW-1:0]    nn;
  logic [2*PairW-1:0]   pp;
  logic                 bypass_q, positive, accept;
  logic                 done_q;
  out_word_t            result_q;

  logic [FieldShellW-1:0] lo, hi;
  logic                   in_range;

  walk_ctrl_t        wctrl;
  walk_stat_t        wstat;
  ram_wr_t           wr;
  ram_rd_t           rd;
  logic [BoundW-1:0] rdata;
  logic [CountW-1:0] walk_count;

  assign accept   = start && !wstat.busy;
  assign busy     = wstat.busy;
  assign positive = !thr_q[ThrW-1] && (thr_q != '0);
  assign n_sat    = (int'(shell_cnt_q) > MaxShells) ? NumW'(MaxShells) : NumW'(shell_cnt_q);

  // order shell indices, smaller first
  assign lo       = (cmd_i.first_shell < cmd_i.second_shell) ? cmd_i.first_shell
                                                             : cmd_i.second_shell;
  assign hi       = (cmd_i.first_shell < cmd_i.second_shell) ? cmd_i.second_shell
                                                             : cmd_i.first_shell;
  assign in_range = int'(hi) < MaxShells;

  always_comb begin
    wr.en   = accept && (cmd_e'(cmd_i.command) == CMD_LOAD) && in_range;
    wr.addr = slot_of(lo, hi);
    wr.data = cmd_i.pair_bound;
  end

  always_comb begin
    wctrl.start  = accept && (cmd_e'(cmd_i.command) == CMD_COUNT);
    wctrl.bypass = (n_sat == '0) || !positive;
  end

  always_comb begin
    largest_d = largest_q;
    if (accept) begin
      case (cmd_e'(cmd_i.command))
        CMD_CLEAR: largest_d = '0;
        CMD_LOAD: begin
          if (in_range && (cmd_i.pair_bound > largest_q)) begin
            largest_d = cmd_i.pair_bound;
          end
        end
        default:   largest_d = largest_q;
      endcase
    end
  end

  // quartet total, registered through pairs_q and then total_q after a shell count write
  assign nn = {{NumW{1'b0}}, n_sat} * ({{NumW{1'b0}}, n_sat} + (2*NumW)'(1));
  assign pp = {{PairW{1'b0}}, pairs_q} * ({{PairW{1'b0}}, pairs_q} + (2*PairW)'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q       <= '0;
      shell_cnt_q <= '0;
      largest_q   <= '0;
      bypass_q    <= 1'b0;
      done_q      <= 1'b0;
      pairs_q     <= '0;
      total_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_PASS_THRESHOLD: thr_q       <= cfg_data_i;
          CFG_SHELL_COUNT:    shell_cnt_q <= cfg_data_i[ShellCntW-1:0];
          default:            thr_q       <= thr_q;
        endcase
      end
      largest_q <= largest_d;
      if (wctrl.start) begin
        bypass_q <= wctrl.bypass;
      end
      done_q  <= wstat.done;
      pairs_q <= PairW'(nn >> 1);
      total_q <= CountW'(pp >> 1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wstat.done) begin
      result_q.passing_count  <= bypass_q ? total_q : walk_count;
      result_q.total_quartets <= total_q;
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;

  sqpc_bound_ram u_ram (
    .clk_i   (clk_i),
    .wr_i    (wr),
    .rd_i    (rd),
    .rdata_o (rdata)
  );

  sqpc_walker u_walker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (wctrl),
    .shells_i  (n_sat),
    .thr_i     (thr_q),
    .largest_i (largest_q),
    .rdata_i   (rdata),
    .rd_o      (rd),
    .stat_o    (wstat),
    .count_o   (walk_count)
  );

endmodule

/* sv/sqpc_bound_ram.sv */
// ----------------------------------------------------------------------------
// sqpc_bound_ram
// Pair bound table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sqpc_bound_ram
  import sqpc_pkg::*;
(
  input  logic              clk_i,
  input  ram_wr_t           wr_i,
  input  ram_rd_t           rd_i,
  output logic [BoundW-1:0] rdata_o
);

  logic [BoundW-1:0] mem [TableSize];
  logic [BoundW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_i.en) begin
      rdata_q <= mem[rd_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/sqpc_walker.sv */
// ----------------------------------------------------------------------------
// sqpc_walker
// Quartet walk sequencer: reads outer pair bound, screens it against the
// largest bound, then streams the remaining pairs through a shared
// multiplier and counts products that reach the threshold; bypass skips the walk.
// ----------------------------------------------------------------------------
`include "schwarz_quartet_pass_counter_top_defines.svh"

module sqpc_walker
  import sqpc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  walk_ctrl_t        ctrl_i,
  input  logic [NumW-1:0]   shells_i,
  input  logic [ThrW-1:0]   thr_i,
  input  logic [BoundW-1:0] largest_i,
  input  logic [BoundW-1:0] rdata_i,
  output ram_rd_t           rd_o,
  output walk_stat_t        stat_o,
  output logic [CountW-1:0] count_o
);

  walk_state_e state_q, state_d;

  logic [ShellW-1:0] i_q, i_d, j_q, j_d, k_q, k_d, l_q, l_d;
  logic [SlotW-1:0]  oslot_q, oslot_d, islot_q, islot_d;
  logic [BoundW-1:0] qij_q, qij_d, mul_a;
  logic [ProdW-1:0]  prod_q;
  logic              v1_q, v2_q;
  logic [CountW-1:0] count_q, count_d;

  logic ge, last_i, last_j, last_k, last_l, outer_last, inner_last;

  assign ge         = {{(ThrW - ProdW){1'b0}}, prod_q} >= thr_i;
  assign last_i     = (NumW'(i_q) + NumW'(1)) == shells_i;
  assign last_j     = (NumW'(j_q) + NumW'(1)) == shells_i;
  assign last_k     = (NumW'(k_q) + NumW'(1)) == shells_i;
  assign last_l     = (NumW'(l_q) + NumW'(1)) == shells_i;
  assign outer_last = last_i && last_j;
  assign inner_last = last_k && last_l;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      WALK_IDLE: begin
        if (ctrl_i.start) begin
          state_d = ctrl_i.bypass ? WALK_SETTLE : WALK_OUTER_RD;
        end
      end
      WALK_SETTLE:    state_d = WALK_DONE;
      WALK_OUTER_RD:  state_d = WALK_OUTER_MUL;
      WALK_OUTER_MUL: state_d = WALK_OUTER_CMP;
      WALK_OUTER_CMP: begin
        if (ge) begin
          state_d = WALK_INNER;
        end else begin
          state_d = outer_last ? WALK_DONE : WALK_OUTER_RD;
        end
      end
      WALK_INNER: begin
        if (inner_last) begin
          state_d = WALK_DRAIN;
        end
      end
      WALK_DRAIN: begin
        if (!v1_q && !v2_q) begin
          state_d = outer_last ? WALK_DONE : WALK_OUTER_RD;
        end
      end
      WALK_DONE:      state_d = WALK_IDLE;
      default:        state_d = WALK_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    rd_o.en     = (state_q == WALK_OUTER_RD) || (state_q == WALK_INNER);
    rd_o.addr   = (state_q == WALK_OUTER_RD) ? oslot_q : islot_q;
    stat_o.busy = state_q != WALK_IDLE;
    stat_o.done = state_q == WALK_DONE;
  end

  // Walk indices, slots and count
  always_comb begin
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    l_d     = l_q;
    oslot_d = oslot_q;
    islot_d = islot_q;
    qij_d   = qij_q;
    count_d = count_q;

    if ((state_q == WALK_IDLE) && ctrl_i.start) begin
      i_d     = '0;
      j_d     = '0;
      oslot_d = '0;
      count_d = '0;
    end

    if (state_q == WALK_OUTER_MUL) begin
      qij_d = rdata_i;
    end

    if ((state_q == WALK_OUTER_CMP) && ge) begin
      k_d     = i_q;
      l_d     = j_q;
      islot_d = oslot_q;
    end

    // advance outer pair after a skip or a finished inner walk
    if (((state_q == WALK_OUTER_CMP) && !ge) ||
        ((state_q == WALK_DRAIN) && !v1_q && !v2_q)) begin
      if (last_j) begin
        i_d     = i_q + ShellW'(1);
        j_d     = i_q + ShellW'(1);
        oslot_d = oslot_q + (SlotW'(MaxShells) - SlotW'(j_q));
      end else begin
        j_d     = j_q + ShellW'(1);
        oslot_d = oslot_q + SlotW'(1);
      end
    end

    if (state_q == WALK_INNER) begin
      if (last_l) begin
        k_d     = k_q + ShellW'(1);
        l_d     = k_q + ShellW'(1);
        islot_d = islot_q + (SlotW'(MaxShells) - SlotW'(l_q));
      end else begin
        l_d     = l_q + ShellW'(1);
        islot_d = islot_q + SlotW'(1);
      end
    end

    if (v2_q && ge) begin
      count_d = count_q + CountW'(1);
    end
  end

  // one multiplier: screen product in OUTER_MUL, quartet product otherwise
  assign mul_a = (state_q == WALK_OUTER_MUL) ? largest_i : qij_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= WALK_IDLE;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      v1_q    <= state_q == WALK_INNER;
      v2_q    <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q     <= i_d;
    j_q     <= j_d;
    k_q     <= k_d;
    l_q     <= l_d;
    oslot_q <= oslot_d;
    islot_q <= islot_d;
    qij_q   <= qij_d;
    count_q <= count_d;
    prod_q  <= ProdW'(mul_a) * ProdW'(rdata_i);
  end

  assign count_o = count_q;

  `SQPC_ASSERT_NOW(a_cmp_after_mul, state_q == WALK_OUTER_CMP,
                   $past(state_q) == WALK_OUTER_MUL, "screen compare without product")
  `SQPC_ASSERT_NOW(a_outer_rd_drained, state_q == WALK_OUTER_RD,
                   !v1_q && !v2_q, "outer read issued with quartet pipe busy")
  `SQPC_ASSERT_NEXT(a_done_to_idle, stat_o.done,
                    state_q == WALK_IDLE && !stat_o.done, "done not a single pulse")
  `SQPC_ASSERT_NOW(a_v1_from_inner, v1_q,
                   $past(rd_o.en) && $past(state_q) == WALK_INNER,
                   "quartet data valid without inner read")

endmodule
